>>> design/hfed_pkg.sv
// hfed_pkg: shared constants and types of the head/foot event delimiter.
// No dependencies; used by head_foot_event_delimiter.
package hfed_pkg;

  // Default framing and position widths
  localparam int HEAD_BYTES_DEFAULT    = 4;
  localparam int FOOT_BYTES_DEFAULT    = 4;
  localparam int POSITION_BITS_DEFAULT = 32;

  // Register file: index taken from paddr[2]
  localparam int          CFG_ADDR_BITS    = 3;
  localparam logic [0:0]  REG_HEAD_PATTERN = 1'b0;
  localparam logic [0:0]  REG_FOOT_PATTERN = 1'b1;

  // Reports and the result queue
  localparam int REPORT_BITS   = 32;
  localparam int OUT_DEPTH     = 4;
  localparam int OUT_PTR_BITS  = 2;
  localparam int OUT_CNT_BITS  = 3;

  typedef struct packed {
    logic [REPORT_BITS-1:0] ev_start;
    logic [REPORT_BITS-1:0] ev_stop;
    logic                   abn;
    logic                   last;
  } report_t;

endpackage

>>> design/head_foot_event_delimiter.sv
// head_foot_event_delimiter: finds head/foot framed events in a byte stream.
// Depends on hfed_pkg (constants, report_t).
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------------
//  in      | sink      | in_valid / in_stall  | data_byte[7:0], end_of_data
//  out     | source    | out_valid / out_stall| event_start[31:0], event_end[31:0],
//          |           |                      | abnormal, last_of_run
//  cfg     | APB slave | psel/penable/pready  | paddr[2:0], pwdata/prdata[31:0]
//
// One byte is taken per cycle. A byte is held in the input register, then the
// match and judging logic updates the stream state and pushes 0..2 reports into a
// 4-entry result queue; the next byte enters in the same cycle.
// The input stalls only when the queue could not absorb two more reports, so the
// sustained rate is one byte per cycle as long as the sink takes one report per cycle.
// rst is synchronous and clears the stream state, the queue and both patterns.
// A stalled report holds at the outputs until the transfer completes.
module head_foot_event_delimiter #(
  parameter int HEAD_BYTES    = hfed_pkg::HEAD_BYTES_DEFAULT,
  parameter int FOOT_BYTES    = hfed_pkg::FOOT_BYTES_DEFAULT,
  parameter int POSITION_BITS = hfed_pkg::POSITION_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  // input stream
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        data_byte,
  input  logic                              end_of_data,
  // event reports
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [hfed_pkg::REPORT_BITS-1:0]  event_start,
  output logic [hfed_pkg::REPORT_BITS-1:0]  event_end,
  output logic                              abnormal,
  output logic                              last_of_run,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [hfed_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  // Window covers the longer of the two patterns; a start is judged once all
  // of its bytes are in the window.
  localparam int WIN       = (HEAD_BYTES > FOOT_BYTES) ? HEAD_BYTES : FOOT_BYTES;
  localparam int SEEN_BITS = $clog2(WIN + 1);
  localparam int PW1       = POSITION_BITS + 1;
  // earliest-start sources: the register, a head at slot u, a foot at slot u
  localparam int SRC       = 2 * WIN + 1;
  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [31:0] head_pattern;
  logic [31:0] foot_pattern;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_pattern <= '0;
      foot_pattern <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        hfed_pkg::REG_HEAD_PATTERN: head_pattern <= pwdata;
        hfed_pkg::REG_FOOT_PATTERN: foot_pattern <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      hfed_pkg::REG_HEAD_PATTERN: prdata = head_pattern;
      hfed_pkg::REG_FOOT_PATTERN: prdata = foot_pattern;
      default:                    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_eod;
  logic       room;
  logic       advance;

  assign in_stall = s1_valid && !room;
  assign advance  = s1_valid && room;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_byte <= data_byte;
      s1_eod  <= end_of_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Stream state
  // ---------------------------------------------------------------------------
  logic [POSITION_BITS-1:0] byte_position;
  logic [7:0]               recent_bytes [WIN];
  logic                     inside_event;
  logic [POSITION_BITS-1:0] open_head_position;
  logic [POSITION_BITS-1:0] earliest_match_start;
  logic [SEEN_BITS-1:0]     seen_count;

  logic [7:0]               rb_next [WIN];
  logic [SEEN_BITS-1:0]     seen_next;
  logic [PW1-1:0]           pos_sum;
  logic [POSITION_BITS-1:0] pos_next;

  always_comb begin
    rb_next[0] = s1_byte;
    for (int i = 1; i < WIN; i++) begin
      rb_next[i] = recent_bytes[i-1];
    end
  end

  assign seen_next = (seen_count < SEEN_BITS'(WIN)) ? seen_count + 1'b1 : seen_count;
  assign pos_sum   = {1'b0, byte_position} + PW1'(1);
  assign pos_next  = pos_sum[POSITION_BITS] ? POS_MAX : pos_sum[POSITION_BITS-1:0];

  // ---------------------------------------------------------------------------
  // Per-slot match logic. Slot t judges the start k = WIN-1-t bytes back from
  // the newest byte; slot 0 is judged every byte, the others only at end of data.
  // All position compares run in parallel; the judging chain below only muxes.
  // ---------------------------------------------------------------------------
  logic [63:0]              head64;
  logic [63:0]              foot64;
  logic [WIN-1:0]           head_hit;
  logic [WIN-1:0]           foot_hit;
  logic [WIN-1:0]           slot_ok;
  logic [POSITION_BITS-1:0] s_pos [WIN];
  logic [POSITION_BITS-1:0] s_head [WIN];   // saturated start + HEAD_BYTES
  logic [POSITION_BITS-1:0] s_foot [WIN];   // saturated start + FOOT_BYTES
  logic [WIN-1:0]           ov_head;
  logic [WIN-1:0]           ov_foot;
  logic [SRC-1:0]           ge [WIN];       // start of slot t >= each earliest source

  assign head64 = {32'b0, head_pattern};
  assign foot64 = {32'b0, foot_pattern};

  always_comb begin
    for (int t = 0; t < WIN; t++) begin
      head_hit[t] = ((WIN - t) >= HEAD_BYTES);
      foot_hit[t] = ((WIN - t) >= FOOT_BYTES);
      for (int i = 0; i < HEAD_BYTES; i++) begin
        if (i <= WIN - 1 - t) begin
          if (rb_next[WIN-1-t-i] != head64[8*(HEAD_BYTES-1-i) +: 8]) begin
            head_hit[t] = 1'b0;
          end
        end
      end
      for (int i = 0; i < FOOT_BYTES; i++) begin
        if (i <= WIN - 1 - t) begin
          if (rb_next[WIN-1-t-i] != foot64[8*(FOOT_BYTES-1-i) +: 8]) begin
            foot_hit[t] = 1'b0;
          end
        end
      end
    end
  end

  always_comb begin
    logic [PW1-1:0] sum_h;
    logic [PW1-1:0] sum_f;
    for (int t = 0; t < WIN; t++) begin
      s_pos[t]   = byte_position - POSITION_BITS'(WIN - 1 - t);
      sum_h      = {1'b0, s_pos[t]} + PW1'(HEAD_BYTES);
      sum_f      = {1'b0, s_pos[t]} + PW1'(FOOT_BYTES);
      ov_head[t] = sum_h[POSITION_BITS];
      ov_foot[t] = sum_f[POSITION_BITS];
      s_head[t]  = ov_head[t] ? POS_MAX : sum_h[POSITION_BITS-1:0];
      s_foot[t]  = ov_foot[t] ? POS_MAX : sum_f[POSITION_BITS-1:0];
      slot_ok[t] = (t == 0 || s1_eod)
                && (SEEN_BITS'(WIN - 1 - t) < seen_next)
                && (POSITION_BITS'(WIN - 1 - t) <= byte_position);
    end
  end

  // Earlier slot u set the bound to start_u + L: slot t is t-u bytes later, so
  // it clears the bound by distance, or by both sitting at the saturated end.
  always_comb begin
    for (int t = 0; t < WIN; t++) begin
      ge[t]    = '0;
      ge[t][0] = (s_pos[t] >= earliest_match_start);
      for (int u = 0; u < t; u++) begin
        ge[t][1+u]     = ((t - u) >= HEAD_BYTES) || ((s_pos[t] == POS_MAX) && ov_head[u]);
        ge[t][1+WIN+u] = ((t - u) >= FOOT_BYTES) || ((s_pos[t] == POS_MAX) && ov_foot[u]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Judging chain, in increasing start order. The bound on the next counted
  // start is tracked as a one-hot source select.
  // ---------------------------------------------------------------------------
  hfed_pkg::report_t        rep [2];
  logic [1:0]               n_rep;
  logic                     inside_v;
  logic [POSITION_BITS-1:0] open_v;
  logic [SRC-1:0]           src_sel;
  logic [POSITION_BITS-1:0] earliest_v;

  always_comb begin
    inside_v = inside_event;
    open_v   = open_head_position;
    src_sel  = SRC'(1);
    n_rep    = 2'd0;
    rep[0]   = '0;
    rep[1]   = '0;
    for (int t = 0; t < WIN; t++) begin
      if (slot_ok[t] && |(src_sel & ge[t])) begin
        if (!inside_v) begin
          if (head_hit[t]) begin
            inside_v = 1'b1;
            open_v   = s_pos[t];
            src_sel  = SRC'(1) << (1 + t);
          end
        end else if (foot_hit[t]) begin
          // normal close: foot wins over a head at the same start
          if (n_rep < 2'd2) begin
            rep[n_rep[0]] = '{ev_start: 32'(open_v), ev_stop: 32'(s_foot[t]),
                              abn: 1'b0, last: 1'b0};
            n_rep = n_rep + 2'd1;
          end
          inside_v = 1'b0;
          src_sel  = SRC'(1) << (1 + WIN + t);
        end else if (head_hit[t]) begin
          // cut at a new head, which opens the next event
          if (n_rep < 2'd2) begin
            rep[n_rep[0]] = '{ev_start: 32'(open_v), ev_stop: 32'(s_pos[t]),
                              abn: 1'b1, last: 1'b0};
            n_rep = n_rep + 2'd1;
          end
          open_v  = s_pos[t];
          src_sel = SRC'(1) << (1 + t);
        end
      end
    end
    // data end closes an open event
    if (s1_eod && inside_v && n_rep < 2'd2) begin
      rep[n_rep[0]] = '{ev_start: 32'(open_v), ev_stop: 32'(pos_next),
                        abn: 1'b1, last: 1'b0};
      n_rep = n_rep + 2'd1;
    end
    if (n_rep == 2'd1) begin
      rep[0].last = 1'b1;
    end else if (n_rep == 2'd2) begin
      rep[1].last = 1'b1;
    end
  end

  always_comb begin
    earliest_v = earliest_match_start;
    for (int u = 0; u < WIN; u++) begin
      if (src_sel[1+u])     earliest_v = s_head[u];
      if (src_sel[1+WIN+u]) earliest_v = s_foot[u];
    end
  end

  // End of data returns the stream to its reset state; recent_bytes is gated
  // by seen_count and needs no clearing.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position        <= '0;
      inside_event         <= 1'b0;
      open_head_position   <= '0;
      earliest_match_start <= '0;
      seen_count           <= '0;
    end else if (advance) begin
      if (s1_eod) begin
        byte_position        <= '0;
        inside_event         <= 1'b0;
        open_head_position   <= '0;
        earliest_match_start <= '0;
        seen_count           <= '0;
      end else begin
        byte_position        <= pos_next;
        inside_event         <= inside_v;
        open_head_position   <= open_v;
        earliest_match_start <= earliest_v;
        seen_count           <= seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      recent_bytes <= rb_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Result queue: up to two pushes and one pop per cycle
  // ---------------------------------------------------------------------------
  hfed_pkg::report_t                   out_q [hfed_pkg::OUT_DEPTH];
  logic [hfed_pkg::OUT_PTR_BITS-1:0]   wr_ptr;
  logic [hfed_pkg::OUT_PTR_BITS-1:0]   rd_ptr;
  logic [hfed_pkg::OUT_CNT_BITS-1:0]   q_count;
  logic [hfed_pkg::OUT_CNT_BITS-1:0]   q_count_next;
  logic [hfed_pkg::OUT_CNT_BITS-1:0]   push_n;
  logic                                pop;

  assign pop    = out_valid && !out_stall;
  // two free entries after this cycle's pop
  assign room   = (q_count - hfed_pkg::OUT_CNT_BITS'(pop))
               <= hfed_pkg::OUT_CNT_BITS'(hfed_pkg::OUT_DEPTH - 2);
  assign push_n = advance ? hfed_pkg::OUT_CNT_BITS'(n_rep) : '0;
  assign q_count_next = q_count - hfed_pkg::OUT_CNT_BITS'(pop) + push_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      wr_ptr  <= wr_ptr + hfed_pkg::OUT_PTR_BITS'(push_n);
      rd_ptr  <= rd_ptr + hfed_pkg::OUT_PTR_BITS'(pop);
      q_count <= q_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (n_rep != 2'd0) begin
        out_q[wr_ptr] <= rep[0];
      end
      if (n_rep == 2'd2) begin
        out_q[wr_ptr + 1'b1] <= rep[1];
      end
    end
  end

  assign out_valid   = (q_count != '0);
  assign event_start = out_q[rd_ptr].ev_start;
  assign event_end   = out_q[rd_ptr].ev_stop;
  assign abnormal    = out_q[rd_ptr].abn;
  assign last_of_run = out_q[rd_ptr].last;

endmodule

>>> tb/tb_head_foot_event_delimiter.sv
// Self-checking testbench for head_foot_event_delimiter: byte streams in, event reports out.
// Depends on hfed_pkg and the design; a class inside the top keeps the expected report order.
`timescale 1ns / 1ps

module tb_head_foot_event_delimiter;

  localparam int HB            = hfed_pkg::HEAD_BYTES_DEFAULT;
  localparam int FB            = hfed_pkg::FOOT_BYTES_DEFAULT;
  localparam int WIN           = (HB > FB) ? HB : FB;
  localparam int MAX_PER_BYTE  = 2;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 222;
  localparam int DRAIN_CYCLES  = 8;
  localparam int WATCHDOG_MAX  = 2000;
  localparam logic [63:0] POS_MAX = 64'h0000_0000_FFFF_FFFF;

  // Frame tracker: mirrors the delimiter's stream state and queues the
  // reports each accepted byte must produce, oldest first.
  class frame_tracker;
    logic [31:0] head_pat;
    logic [31:0] foot_pat;
    logic [63:0] next_pos;
    logic [63:0] open_pos;
    logic [63:0] min_start;
    logic [7:0]  window [WIN];
    bit          in_frame;
    int unsigned fill;
    hfed_pkg::report_t due_reports [$];
    hfed_pkg::report_t step_reports [$];
    int unsigned errors;

    function new();
      head_pat = '0;
      foot_pat = '0;
      errors   = 0;
      restart();
    endfunction

    function void restart();
      next_pos  = '0;
      open_pos  = '0;
      min_start = '0;
      in_frame  = 1'b0;
      fill      = 0;
      foreach (window[i]) window[i] = 8'h00;
    endfunction

    function logic [63:0] sat_add(logic [63:0] a, int unsigned b);
      logic [63:0] r;
      r = a + b;
      return (r > POS_MAX) ? POS_MAX : r;
    endfunction

    // Does the pattern start k bytes back from the newest byte?
    function bit hit(logic [31:0] pat, int unsigned len, int unsigned k);
      logic [7:0] want;
      if (k + 1 < len) return 1'b0;
      for (int i = 0; i < len; i++) begin
        want = pat[(len - 1 - i) * 8 +: 8];
        if (window[k - i] != want) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void add_report(logic [63:0] s, logic [63:0] e, bit abn);
      hfed_pkg::report_t r;
      if (step_reports.size() >= MAX_PER_BYTE) return;
      r.ev_start = s[31:0];
      r.ev_stop  = e[31:0];
      r.abn      = abn;
      r.last     = 1'b0;
      step_reports = {step_reports, r};
    endfunction

    // Judge the start k bytes back; p is the newest byte's position.
    function void judge(int unsigned k, logic [63:0] p);
      logic [63:0] s;
      bit head_hit;
      bit foot_hit;
      if (k >= fill || k > p) return;
      s = p - k;
      if (s < min_start) return;
      head_hit = hit(head_pat, HB, k);
      foot_hit = hit(foot_pat, FB, k);
      if (!in_frame) begin
        if (head_hit) begin
          in_frame  = 1'b1;
          open_pos  = s;
          min_start = sat_add(s, HB);
        end
      end else if (foot_hit) begin
        // foot wins over a head at the same start
        add_report(open_pos, sat_add(s, FB), 1'b0);
        in_frame  = 1'b0;
        min_start = sat_add(s, FB);
      end else if (head_hit) begin
        add_report(open_pos, s, 1'b1);
        open_pos  = s;
        min_start = sat_add(s, HB);
      end
    endfunction

    function void take_byte(logic [7:0] b, bit eod);
      logic [63:0] p;
      for (int i = WIN - 1; i > 0; i--) window[i] = window[i - 1];
      window[0] = b;
      if (fill < WIN) fill++;
      p        = next_pos;
      next_pos = sat_add(p, 1);
      step_reports.delete();
      judge(WIN - 1, p);
      if (eod) begin
        // flush the starts still in the window, then close what is open
        for (int k = WIN - 2; k >= 0; k--) judge(k, p);
        if (in_frame) add_report(open_pos, next_pos, 1'b1);
        restart();
      end
      if (step_reports.size() > 0) step_reports[step_reports.size() - 1].last = 1'b1;
      foreach (step_reports[i]) due_reports = {due_reports, step_reports[i]};
    endfunction

    function void match_report(hfed_pkg::report_t got);
      hfed_pkg::report_t want;
      if (due_reports.size() == 0) begin
        $error("unexpected report: start %0d end %0d abnormal %0b",
               got.ev_start, got.ev_stop, got.abn);
        errors++;
        return;
      end
      want = due_reports.pop_front();
      if (got.ev_start !== want.ev_start) begin
        $error("event_start: expected %0d, got %0d", want.ev_start, got.ev_start);
        errors++;
      end
      if (got.ev_stop !== want.ev_stop) begin
        $error("event_end: expected %0d, got %0d", want.ev_stop, got.ev_stop);
        errors++;
      end
      if (got.abn !== want.abn) begin
        $error("abnormal: expected %0b, got %0b", want.abn, got.abn);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last_of_run: expected %0b, got %0b", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  // Block ports; everything the testbench drives starts at a known value.
  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte   = 8'h00;
  logic        end_of_data = 1'b0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  logic [31:0] event_start;
  logic [31:0] event_end;
  logic        abnormal;
  logic        last_of_run;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [hfed_pkg::CFG_ADDR_BITS-1:0] paddr = '0;
  logic [31:0] pwdata      = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  frame_tracker tracker;

  // Idle odds in percent per cycle for the sender and the receiver, and the
  // odds (one in eod_odds, 0 = never) that a random byte ends the stream.
  int unsigned send_gap   = 0;
  int unsigned stall_pct  = 0;
  int unsigned eod_odds   = 0;
  int unsigned bytes_sent = 0;
  int unsigned quiet      = 0;

  head_foot_event_delimiter dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .end_of_data (end_of_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .event_start (event_start),
    .event_end   (event_end),
    .abnormal    (abnormal),
    .last_of_run (last_of_run),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #1 clk = ~clk;

  // Report side: every transfer is checked against the oldest expected
  // report, then stall is redrawn for the next cycle.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      tracker.match_report(hfed_pkg::report_t'{event_start, event_end, abnormal, last_of_run});
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog: any transfer on any port resets the count of quiet cycles.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_MAX) begin
      $error("no transfer for %0d cycles", quiet);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // One input transfer. Valid stays high on return so a following byte can
  // go out back to back; whoever idles next lowers it.
  task automatic push_byte(input logic [7:0] b, input bit eod);
    while ($urandom_range(99) < send_gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    data_byte   <= b;
    end_of_data <= eod;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.take_byte(b, eod);
    bytes_sent++;
  endtask

  function automatic bit chance_eod();
    return (eod_odds != 0) && ($urandom_range(eod_odds - 1) == 0);
  endfunction

  // First n bytes of a pattern, most significant first; close ends the
  // stream on the last byte.
  task automatic push_pattern(input logic [31:0] pat, input int n, input bit close);
    for (int i = 0; i < n; i++) begin
      push_byte(pat[31 - 8 * i -: 8], (close && i == n - 1) || chance_eod());
    end
  endtask

  // Filler mixes fully random bytes with bytes of the patterns so partial
  // matches turn up all the time.
  task automatic filler(input int n);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0, 1:    b = $urandom_range(255);
        2:       b = tracker.head_pat[8 * $urandom_range(3) +: 8];
        default: b = tracker.foot_pat[8 * $urandom_range(3) +: 8];
      endcase
      push_byte(b, chance_eod());
    end
  endtask

  // Stop sending and let every expected report out; the extra cycles cover
  // bytes still being judged that produce no report.
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.due_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write, then a read back of the same register.
  task automatic write_reg(input logic [0:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== value) begin
      $error("register %0d readback: expected %h, got %h", idx, value, prdata);
      tracker.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_patterns(input logic [31:0] head, input logic [31:0] foot);
    drain();
    write_reg(hfed_pkg::REG_HEAD_PATTERN, head);
    write_reg(hfed_pkg::REG_FOOT_PATTERN, foot);
    tracker.head_pat = head;
    tracker.foot_pat = foot;
  endtask

  // Patterns over a two-letter alphabet overlap themselves and each other.
  function automatic logic [31:0] two_letter_word();
    logic [31:0] w;
    for (int i = 0; i < 4; i++) w[8 * i +: 8] = $urandom_range(1) ? 8'h12 : 8'h34;
    return w;
  endfunction

  // One random sequence: mostly complete frames with random content, the
  // rest cut frames, stray feet, pattern fragments and noise.
  task automatic random_sequence();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) begin
      push_pattern(tracker.head_pat, 4, 1'b0);
      filler($urandom_range(6));
      push_pattern(tracker.foot_pat, 4, 1'b0);
      filler($urandom_range(3));
    end else if (r < 70) begin
      push_pattern(tracker.head_pat, 4, 1'b0);
      filler($urandom_range(5));
      push_pattern(tracker.head_pat, 4, 1'b0);
    end else if (r < 80) begin
      push_pattern(tracker.foot_pat, 4, 1'b0);
      filler($urandom_range(3));
    end else if (r < 90) begin
      push_pattern($urandom_range(1) ? tracker.head_pat : tracker.foot_pat,
                   $urandom_range(1, 3), 1'b0);
      filler($urandom_range(1, 3));
    end else begin
      filler($urandom_range(1, 8));
    end
  endtask

  initial begin
    logic [31:0] head_set [PHASES];
    logic [31:0] foot_set [PHASES];
    int unsigned phase_base;
    bit          paused;

    // distinct bytes, then the extremes both ways, then head equal to foot,
    // then self-overlapping words, then anything
    head_set = '{32'hAABB_CCDD, 32'h0000_0000, 32'hFFFF_FFFF,
                 32'h5A5A_5A5A, two_letter_word(), $urandom()};
    foot_set = '{32'h1122_3344, 32'hFFFF_FFFF, 32'h0000_0000,
                 32'h5A5A_5A5A, two_letter_word(), $urandom()};

    tracker = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < PHASES; ph++) begin
      // sender idles lightly / receiver heavily, then swapped, then no idling
      send_gap  = (ph < 2) ? 12 : (ph < 4) ? 47 : 0;
      stall_pct = (ph < 2) ? 47 : (ph < 4) ? 12 : 0;
      set_patterns(head_set[ph], foot_set[ph]);

      if (ph == 0) begin
        eod_odds = 0;
        // clean frame: head straight into foot
        push_pattern(head_set[0], 4, 1'b0);
        push_pattern(foot_set[0], 4, 1'b0);
        // head cut by a second head, which the data end then cuts; both
        // reports leave on the same byte
        push_pattern(head_set[0], 4, 1'b0);
        push_pattern(head_set[0], 4, 1'b1);
        // extreme bytes, then a head with no foot before the data ends
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_pattern(head_set[0], 4, 1'b1);
        // one-byte stream with nothing open
        push_byte(8'h55, 1'b1);
      end

      eod_odds   = 64;
      phase_base = bytes_sent;
      paused     = 1'b0;
      while (bytes_sent - phase_base < PHASE_ITEMS) begin
        random_sequence();
        // hold the sender mid-stream until every report is out
        if (!paused && bytes_sent - phase_base >= PHASE_ITEMS / 2) begin
          drain();
          paused = 1'b1;
        end
      end
    end

    drain();
    if (tracker.due_reports.size() != 0) begin
      $error("%0d expected reports never arrived", tracker.due_reports.size());
      tracker.errors++;
    end
    if (tracker.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/hfed_pkg.sv
design/head_foot_event_delimiter.sv
tb/tb_head_foot_event_delimiter.sv
